@@ design/imu_sync_frame_parser_top_defines.svh @@
// Assertion macros shared by the frame parser modules.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef IMU_SYNC_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_SYNC_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define IMU_SFP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imu_sfp assertion failed");

// Checks that a condition never holds.
`define IMU_SFP_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("imu_sfp forbidden condition seen");

`else

`define IMU_SFP_ASSERT(label, prop)
`define IMU_SFP_NEVER(label, cond)

`endif

`endif

@@ design/imu_sfp_pkg.sv @@
// Shared constants and types of the sync frame parser.
// No dependencies; used by the top level and the result buffer.
package imu_sfp_pkg;

    localparam logic [7:0] HDR_FIRST     = 8'h7F;
    localparam logic [7:0] HDR_SECOND    = 8'h80;
    localparam int         FRAME_BYTES   = 23;
    localparam int         PAYLOAD_BYTES = 20;
    localparam int         WORD_COUNT    = 9;
    // The oldest window byte is never read, so the chain keeps one byte less.
    localparam int         CELL_COUNT    = FRAME_BYTES - 1;
    localparam int         SEEN_W        = 9;
    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic [7:0] LIMIT_RESET   = 8'd64;

    localparam logic STATUS_FRAME = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic                        status;
        logic [WORD_COUNT-1:0][15:0] words;
    } result_t;

endpackage

@@ design/imu_sfp_cell.sv @@
// One byte cell of the sliding window chain.
// Depends on nothing but its neighbor's byte; no package content used.
module imu_sfp_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clr,
    input  logic [7:0] d_in,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (shift_en)
        begin
            byte_next = clr ? 8'd0 : d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

@@ design/imu_sfp_outbuf.sv @@
// Two-entry result buffer: output register plus a skid register.
// Uses imu_sfp_pkg for the result type and the assertion macro header.
`include "imu_sync_frame_parser_top_defines.svh"

module imu_sfp_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  imu_sfp_pkg::result_t  res,
    input  logic                  out_stall,
    output logic                  out_valid,
    output imu_sfp_pkg::result_t  out_res,
    output logic                  full
);
    import imu_sfp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = res_valid;
                skid_next       = res;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            // The output register is held, so the new result waits in the skid.
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign full      = skid_valid_reg;

    `IMU_SFP_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg)
    `IMU_SFP_NEVER(a_no_result_when_full, res_valid && skid_valid_reg)
    `IMU_SFP_ASSERT(a_skid_fill_on_hold,
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))

endmodule

@@ design/imu_sync_frame_parser_top.sv @@
// Top level of the sync frame parser: window chain, search control, result buffer.
// Depends on imu_sfp_pkg, imu_sfp_cell, imu_sfp_outbuf and the assertion header.
//
//   Channel  Signals                          Direction  Moves
//   input    in_valid, in_stall, data_byte,   in         one stream byte per transfer
//            restart
//   output   out_valid, out_stall, status,    out        one frame or error result
//            accel_*, gyro_*, *_angle
//   config   cfg_wr_en, cfg_wr_data           in         search_limit write
//
// One byte is taken per cycle while in_stall is low. The result of the byte that ends
// the search goes to the output register, or to the skid while the output is held.
// Reset clears the window cells, sum, byte count, done flag, and sets the limit to 64.
// A stalled output holds its result while one more result can wait in the skid;
// the input stalls only while that skid register is occupied.
`include "imu_sync_frame_parser_top_defines.svh"

module imu_sync_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] accel_x,
    output logic [15:0] accel_y,
    output logic [15:0] accel_z,
    output logic [15:0] gyro_x,
    output logic [15:0] gyro_y,
    output logic [15:0] gyro_z,
    output logic [15:0] roll_angle,
    output logic [15:0] pitch_angle,
    output logic [15:0] azimuth_angle
);
    import imu_sfp_pkg::*;

    logic [7:0]        limit_reg;
    logic [7:0]        limit_next;
    logic [7:0]        sum_reg;
    logic [7:0]        sum_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic              done_reg;
    logic              done_next;

    logic [7:0]        win [CELL_COUNT];
    logic              in_fire;
    logic              active;
    logic              buf_full;
    logic [7:0]        sum_prev;
    logic [7:0]        drop_byte;
    logic [SEEN_W-1:0] seen_prev;
    logic [SEEN_W-1:0] seen_new;
    logic [SEEN_W-1:0] cand_k;
    logic              win_full;
    logic              frame_ok;
    logic              limit_hit;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    assign in_stall = buf_full;
    assign in_fire  = in_valid && !in_stall;
    // A restart byte clears the done flag before it is taken in.
    assign active   = in_fire && (restart || !done_reg);

    genvar gi;
    generate
        for (gi = 0; gi < CELL_COUNT; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                imu_sfp_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (active),
                    .clr      (1'b0),
                    .d_in     (data_byte),
                    .q        (win[gi])
                );
            end
            else
            begin : g_body
                imu_sfp_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (active),
                    .clr      (restart),
                    .d_in     (win[gi-1]),
                    .q        (win[gi])
                );
            end
        end
    endgenerate

    assign sum_prev  = restart ? 8'd0 : sum_reg;
    assign drop_byte = restart ? 8'd0 : win[PAYLOAD_BYTES-1];
    assign seen_prev = restart ? '0 : seen_reg;
    assign seen_new  = (seen_prev == SEEN_MAX) ? seen_prev : seen_prev + SEEN_W'(1);
    assign win_full  = seen_new >= SEEN_W'(FRAME_BYTES);
    assign cand_k    = seen_new - SEEN_W'(FRAME_BYTES);

    // The window is read before the shift: old entry j becomes entry j + 1.
    assign frame_ok  = (cand_k < {1'b0, limit_reg})
                    && (win[FRAME_BYTES-2] == HDR_FIRST)
                    && (win[FRAME_BYTES-3] == HDR_SECOND)
                    && (~sum_prev == data_byte);
    assign limit_hit = ({1'b0, cand_k} + (SEEN_W+1)'(1)) >= (SEEN_W+1)'(limit_reg);
    assign res_valid = active && win_full && (frame_ok || limit_hit);

    always_comb
    begin
        res.status = frame_ok ? STATUS_FRAME : STATUS_ERROR;
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            if (frame_ok)
            begin
                res.words[i] = {win[PAYLOAD_BYTES-2-2*i], win[PAYLOAD_BYTES-1-2*i]};
            end
            else
            begin
                res.words[i] = 16'd0;
            end
        end
    end

    always_comb
    begin
        limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        done_next  = done_reg;
        if (active)
        begin
            sum_next  = sum_prev + data_byte - drop_byte;
            seen_next = seen_new;
            done_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            sum_reg   <= 8'd0;
            seen_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            limit_reg <= limit_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
    end

    imu_sfp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .full      (buf_full)
    );

    assign status        = out_res.status;
    assign accel_x       = out_res.words[0];
    assign accel_y       = out_res.words[1];
    assign accel_z       = out_res.words[2];
    assign gyro_x        = out_res.words[3];
    assign gyro_y        = out_res.words[4];
    assign gyro_z        = out_res.words[5];
    assign roll_angle    = out_res.words[6];
    assign pitch_angle   = out_res.words[7];
    assign azimuth_angle = out_res.words[8];

    `IMU_SFP_ASSERT(a_done_after_result, res_valid |=> done_reg)
    `IMU_SFP_ASSERT(a_done_holds, done_reg && !(in_fire && restart) |=> done_reg)
    `IMU_SFP_ASSERT(a_no_early_result,
        (in_fire && !restart && (seen_reg < SEEN_W'(FRAME_BYTES - 1))) |-> !res_valid)

endmodule

@@ bench/imu_sync_frame_parser_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for imu_sync_frame_parser_top: directed and random byte streams, with a
// built-in frame search predictor that checks every result field as it is transferred.
// Depends on imu_sfp_pkg and the imu_sync_frame_parser_top design sources.
module imu_sync_frame_parser_top_tb;

    import imu_sfp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES = 1000;
    localparam int PHASE_BYTES = 250;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] azimuth_angle;

    imu_sync_frame_parser_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .gyro_x        (gyro_x),
        .gyro_y        (gyro_y),
        .gyro_z        (gyro_z),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .azimuth_angle (azimuth_angle)
    );

    // Predictor state of the frame search.
    logic [7:0] win_bytes [FRAME_BYTES];
    int unsigned win_fill;
    logic [7:0] body_sum;
    int unsigned seen_count;
    bit search_over;
    logic [7:0] limit_reg;

    result_t due_results [$];
    int errors;
    int fed_bytes;
    bit calm_run;
    int hold_off_cycles;

    string word_names [WORD_COUNT] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
                                       "gyro_z", "roll_angle", "pitch_angle",
                                       "azimuth_angle"};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void note_error(input string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endfunction

    task automatic start_buffer;
        for (int i = 0; i < FRAME_BYTES; i++)
            win_bytes[i] = 8'h00;
        win_fill = 0;
        body_sum = 8'h00;
        seen_count = 0;
        search_over = 1'b0;
    endtask

    // Takes one accepted byte into the predictor and queues the result it closes, if any.
    task automatic parse_byte(input logic [7:0] value, input logic first);
        logic [7:0] prev_sum;
        int unsigned k;
        bit good;
        result_t res;
        if (first)
            start_buffer();
        if (search_over)
            return;
        prev_sum = body_sum;
        body_sum = body_sum + value - win_bytes[PAYLOAD_BYTES - 1];
        for (int i = FRAME_BYTES - 1; i > 0; i--)
            win_bytes[i] = win_bytes[i - 1];
        win_bytes[0] = value;
        if (win_fill < FRAME_BYTES)
            win_fill++;
        if (seen_count < 511)
            seen_count++;
        if (win_fill < FRAME_BYTES)
            return;
        k = seen_count - FRAME_BYTES;
        good = (k < limit_reg) && (win_bytes[22] == HDR_FIRST) && (win_bytes[21] == HDR_SECOND)
               && (8'(~prev_sum) == win_bytes[0]);
        if (good)
        begin
            res.status = STATUS_FRAME;
            for (int i = 0; i < WORD_COUNT; i++)
                res.words[i] = {win_bytes[19 - 2 * i], win_bytes[20 - 2 * i]};
            due_results.push_back(res);
            search_over = 1'b1;
        end
        else if (k + 1 >= limit_reg)
        begin
            res = '0;
            res.status = STATUS_ERROR;
            due_results.push_back(res);
            search_over = 1'b1;
        end
    endtask

    task automatic check_result;
        result_t want;
        result_t got;
        got.status = status;
        got.words[0] = accel_x;
        got.words[1] = accel_y;
        got.words[2] = accel_z;
        got.words[3] = gyro_x;
        got.words[4] = gyro_y;
        got.words[5] = gyro_z;
        got.words[6] = roll_angle;
        got.words[7] = pitch_angle;
        got.words[8] = azimuth_angle;
        if (due_results.size() == 0)
        begin
            note_error($sformatf("result with no expectation: status %0d", got.status));
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status)
            note_error($sformatf("status: expected %0d, got %0d", want.status, got.status));
        for (int i = 0; i < WORD_COUNT; i++)
            if (got.words[i] !== want.words[i])
                note_error($sformatf("%s: expected %h, got %h", word_names[i],
                                     want.words[i], got.words[i]));
    endtask

    // Output transfers are checked before the input transfer of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                parse_byte(data_byte, restart);
        end
    end

    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            out_stall <= !calm_run && ($urandom_range(99) < 34);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("imu_sync_frame_parser_top_tb: errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] value, input logic first);
        while (!calm_run && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        restart <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        fed_bytes++;
    endtask

    // Filler bytes; header-free filler can never complete a frame.
    task automatic send_filler(input int count, input bit first, input bit header_free);
        logic [7:0] value;
        for (int n = 0; n < count; n++)
        begin
            if (header_free)
                value = 8'($urandom_range(0, 8'h7E));
            else
                case ($urandom_range(0, 3))
                    0: value = HDR_FIRST;
                    1: value = HDR_SECOND;
                    default: value = 8'($urandom);
                endcase
            send_byte(value, first && (n == 0));
        end
    endtask

    function automatic logic [159:0] random_body();
        logic [159:0] body;
        for (int j = 0; j < PAYLOAD_BYTES; j++)
            body[8 * j +: 8] = 8'($urandom);
        return body;
    endfunction

    task automatic send_frame(input logic [159:0] body, input bit first, input bit bad_check);
        logic [7:0] sum;
        logic [7:0] check;
        sum = 8'h00;
        for (int j = 0; j < PAYLOAD_BYTES; j++)
            sum = sum + body[8 * j +: 8];
        check = ~sum;
        if (bad_check)
            check = check ^ 8'($urandom_range(1, 255));
        send_byte(HDR_FIRST, first);
        send_byte(HDR_SECOND, 1'b0);
        for (int j = 0; j < PAYLOAD_BYTES; j++)
            send_byte(body[8 * j +: 8], 1'b0);
        send_byte(check, 1'b0);
    endtask

    // Stops sending and waits until every expected result has been transferred.
    task automatic settle;
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called right after settle, so the block is idle.
    task automatic set_limit(input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        limit_reg = value;
    endtask

    task automatic test_frame_extremes;
        send_frame({20{8'hFF}}, 1'b1, 1'b0);
        send_frame({20{8'h00}}, 1'b1, 1'b0);
        // Bytes after a decoded frame are ignored until the next restart.
        send_byte(HDR_FIRST, 1'b0);
        send_frame({10{16'hAA55}}, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_checksum_skip;
        // A bad check byte is passed over and the header at an odd offset is found.
        send_filler(4, 1'b1, 1'b1);
        send_frame(random_body(), 1'b0, 1'b1);
        send_frame(random_body(), 1'b0, 1'b0);
        settle();
    endtask

    task automatic test_search_limit;
        set_limit(8'd3);
        send_filler(2, 1'b1, 1'b1);
        send_frame(random_body(), 1'b0, 1'b0);
        send_filler(3, 1'b1, 1'b1);
        send_frame(random_body(), 1'b0, 1'b0);
        settle();
        set_limit(8'd0);
        send_filler(FRAME_BYTES, 1'b1, 1'b1);
        settle();
        set_limit(8'd1);
        send_frame(random_body(), 1'b1, 1'b0);
        settle();
        set_limit(8'd255);
        send_filler(280, 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_midsearch_changes;
        set_limit(8'd64);
        send_filler(30, 1'b1, 1'b1);
        settle();
        // The next candidate already lies beyond the lowered limit.
        set_limit(8'd5);
        send_byte(8'($urandom), 1'b0);
        settle();
        set_limit(8'd64);
        send_filler(10, 1'b1, 1'b0);
        send_frame(random_body(), 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_flow_control;
        calm_run = 1'b1;
        repeat (3) send_frame(random_body(), 1'b1, 1'b0);
        settle();
        // Results pile up behind the held output until the input transfer stalls.
        hold_off_cycles = HOLD_CYCLES;
        repeat (8) send_frame(random_body(), 1'b1, 1'b0);
        settle();
        calm_run = 1'b0;
    endtask

    task automatic send_random_buffer(inout int ignored);
        int pmax;
        int prefix;
        int kind;
        int mark;
        pmax = (limit_reg > 30) ? 30 : ((limit_reg > 0) ? limit_reg - 1 : 0);
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            prefix = $urandom_range(0, pmax);
            send_filler(prefix, 1'b1, 1'b0);
            if ($urandom_range(0, 3) == 0)
            begin
                send_frame(random_body(), prefix == 0, 1'b1);
                prefix = 1;
            end
            send_frame(random_body(), prefix == 0, 1'b0);
        end
        else if (kind <= 7)
            send_filler(limit_reg + 24, 1'b1, 1'b0);
        else if (kind == 8)
            send_filler($urandom_range(1, 20), 1'b1, 1'b0);
        else
            repeat ($urandom_range(1, 10))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        mark = fed_bytes;
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
        ignored += fed_bytes - mark;
    endtask

    task automatic test_random_streams;
        int start;
        int ignored;
        int phase_start;
        start = fed_bytes;
        ignored = 0;
        while (fed_bytes - start - ignored < RANDOM_BYTES)
        begin
            settle();
            case ($urandom_range(0, 7))
                0: set_limit(8'd2);
                1: set_limit(8'd255);
                2: set_limit(8'd64);
                3: set_limit(8'($urandom_range(0, 1)));
                default: set_limit(8'($urandom_range(3, 254)));
            endcase
            phase_start = fed_bytes;
            while (fed_bytes - phase_start < PHASE_BYTES)
                send_random_buffer(ignored);
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'h00;
        in_valid = 1'b0;
        data_byte = 8'h00;
        restart = 1'b0;
        errors = 0;
        fed_bytes = 0;
        calm_run = 1'b0;
        hold_off_cycles = 0;
        limit_reg = LIMIT_RESET;
        start_buffer();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_frame_extremes();
        test_checksum_skip();
        test_search_limit();
        test_midsearch_changes();
        test_flow_control();
        test_random_streams();

        settle();
        if (due_results.size() != 0)
            note_error($sformatf("%0d results never arrived", due_results.size()));
        if (errors == 0)
            $display("imu_sync_frame_parser_top_tb: clean");
        else
            $display("imu_sync_frame_parser_top_tb: errors");
        $finish;
    end

endmodule
